/* hdl/ubx_pkg.sv */
// shared types and constants for the ubx frame receiver
package ubx_pkg;

	localparam int unsigned LEN_W = 17;
	localparam int unsigned OFF_W = 16;
	localparam int unsigned TYPE_W = 16;

	localparam logic [7:0] SYNC_FIRST = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;
	localparam logic [TYPE_W-1:0] TYPE_NAV_PVT = 16'h0107;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 17'd1024;
	localparam logic [LEN_W-1:0] FRAME_OVERHEAD = 17'd8;

	// byte positions within a frame, counted from the first sync byte
	localparam logic [LEN_W-1:0] POS_CLASS = 17'd2;
	localparam logic [LEN_W-1:0] POS_ID = 17'd3;
	localparam logic [LEN_W-1:0] POS_LEN_LO = 17'd4;
	localparam logic [LEN_W-1:0] POS_LEN_HI = 17'd5;
	localparam logic [LEN_W-1:0] POS_PAYLOAD = 17'd6;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_PAYLOAD = 3'd1,
		EV_GOOD_PVT = 3'd2,
		EV_GOOD_OTHER = 3'd3,
		EV_BAD_SUM = 3'd4,
		EV_TOO_LONG = 3'd5
	} ubx_event_t;

	typedef struct packed {
		ubx_event_t ev;
		logic [7:0] pbyte;
		logic [OFF_W-1:0] poff;
		logic [TYPE_W-1:0] mtype;
	} ubx_result_t;

endpackage

/* hdl/ubx_parse.sv */
// frame state and per-byte parse logic: sync hunt, header, checksum, verdict
module ubx_parse
	import ubx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  logic [LEN_W-1:0] max_len,
	output ubx_result_t      res,
	output logic             hunting
);

	logic [7:0]        prev_q, prev_d;
	logic [LEN_W-1:0]  count_q, count_d;
	logic [LEN_W-1:0]  flen_q, flen_d;
	logic [TYPE_W-1:0] ftype_q, ftype_d;
	logic [7:0]        sum_a_q, sum_a_d;
	logic [7:0]        sum_b_q, sum_b_d;
	logic              match_q, match_d;
	logic [7:0]        add_a, add_b;
	logic [LEN_W:0]    idx_p2;
	logic [LEN_W-1:0]  count_inc;
	logic [LEN_W-1:0]  len_total;
	logic [LEN_W-1:0]  poff_full;

	// running fletcher sums with the current byte folded in
	assign add_a = sum_a_q + rx_byte;
	assign add_b = sum_b_q + add_a;
	assign idx_p2 = {1'b0, count_q} + (LEN_W+1)'(2);
	assign count_inc = count_q + LEN_W'(1);
	assign len_total = {1'b0, rx_byte, flen_q[7:0]} + FRAME_OVERHEAD;
	assign poff_full = count_q - POS_PAYLOAD;
	assign hunting = (count_q == '0);

	// next state and result for one byte
	always_comb begin
		prev_d = prev_q;
		count_d = count_q;
		flen_d = flen_q;
		ftype_d = ftype_q;
		sum_a_d = sum_a_q;
		sum_b_d = sum_b_q;
		match_d = match_q;
		res.ev = EV_NONE;
		res.pbyte = '0;
		res.poff = '0;
		if (count_q == '0) begin
			if (prev_q == SYNC_FIRST && rx_byte == SYNC_SECOND) begin
				count_d = POS_CLASS;
				sum_a_d = '0;
				sum_b_d = '0;
				match_d = 1'b0;
			end
			prev_d = rx_byte;
		end else begin
			count_d = count_inc;
			priority if (count_q == POS_CLASS) begin
				ftype_d = {rx_byte, 8'h00};
				sum_a_d = add_a;
				sum_b_d = add_b;
			end else if (count_q == POS_ID) begin
				ftype_d = {ftype_q[15:8], rx_byte};
				sum_a_d = add_a;
				sum_b_d = add_b;
			end else if (count_q == POS_LEN_LO) begin
				flen_d = {9'd0, rx_byte};
				sum_a_d = add_a;
				sum_b_d = add_b;
			end else if (count_q == POS_LEN_HI) begin
				flen_d = len_total;
				sum_a_d = add_a;
				sum_b_d = add_b;
				if (len_total > max_len) begin
					count_d = '0;
					res.ev = EV_TOO_LONG;
				end
			end else if (idx_p2 < {1'b0, flen_q}) begin
				sum_a_d = add_a;
				sum_b_d = add_b;
				res.ev = EV_PAYLOAD;
				res.pbyte = rx_byte;
				res.poff = poff_full[OFF_W-1:0];
			end else if (idx_p2 == {1'b0, flen_q}) begin
				match_d = (rx_byte == sum_a_q);
			end else begin
				count_d = '0;
				if (match_q && rx_byte == sum_b_q)
					res.ev = (ftype_q == TYPE_NAV_PVT) ? EV_GOOD_PVT : EV_GOOD_OTHER;
				else
					res.ev = EV_BAD_SUM;
			end
		end
		res.mtype = ftype_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			count_q <= '0;
			flen_q <= '0;
			ftype_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			match_q <= 1'b0;
		end else if (step) begin
			prev_q <= prev_d;
			count_q <= count_d;
			flen_q <= flen_d;
			ftype_q <= ftype_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			match_q <= match_d;
		end
	end

endmodule

/* hdl/ubx_frame_receiver.sv */
// top level of the ubx frame receiver: input register, parser, result register
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------
//  in      | in_valid / in_stall   | rx_byte
//  out     | out_valid / out_stall | event_res, payload_byte, payload_offset, msg_type
//  cfg     | cfg_valid / cfg_ready | cfg_data (max_frame_len)
//
// one item per cycle sustained while out_stall stays low; an item passes from the input
// register through the parser into the result register, where its result becomes valid.
// the parser updates its frame state as an item moves from the input register
// into the result register, one byte per step.
// reset clears the frame state and sets max_frame_len to 1024.
// a stalled result holds the result register; the input register then fills
// and in_stall rises.
module ubx_frame_receiver
	import ubx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       event_res,
	output logic [7:0]       payload_byte,
	output logic [OFF_W-1:0] payload_offset,
	output logic [TYPE_W-1:0] msg_type,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] cfg_data
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             adv;
	logic             in_take;
	logic [LEN_W-1:0] max_len_q;
	ubx_result_t      res;
	ubx_result_t      res_s2;
	logic             hunting;

	// pipeline moves when the result register is free or being emptied
	assign adv = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser
	ubx_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.max_len (max_len_q),
		.res     (res),
		.hunting (hunting)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign event_res = res_s2.ev;
	assign payload_byte = res_s2.pbyte;
	assign payload_offset = res_s2.poff;
	assign msg_type = res_s2.mtype;

`ifndef SYNTH
	// a verdict or a drop sends the parser back to hunting
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && (res.ev == EV_GOOD_PVT || res.ev == EV_GOOD_OTHER ||
			res.ev == EV_BAD_SUM || res.ev == EV_TOO_LONG) |=> hunting)
		else $error("parser not hunting after end of frame");

	// only payload items carry byte and offset
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_PAYLOAD |-> payload_byte == '0 && payload_offset == '0)
		else $error("payload fields set on a non-payload item");

	// an empty input register never stalls the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

	// a byte taken into the parser always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("result lost after parser step");
`endif

endmodule

/* dv/ubx_frame_checker.sv */
// checker for the ubx frame receiver: follows the parser state and compares every result item
module ubx_frame_checker
	import ubx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [7:0]        rx_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [2:0]        event_res,
	input  logic [7:0]        payload_byte,
	input  logic [OFF_W-1:0]  payload_offset,
	input  logic [TYPE_W-1:0] msg_type,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [LEN_W-1:0]  cfg_data,
	output int                fail_count,
	output int                pending,
	output int                n_pvt,
	output int                n_other,
	output int                n_bad_sum,
	output int                n_too_long,
	output int                n_payload
);

	localparam int REPORT_LINES = 40;

	// own copy of the frame state and the length limit
	logic [7:0]        hunt_prev;
	logic [LEN_W-1:0]  frame_pos;
	logic [LEN_W-1:0]  frame_total;
	logic [LEN_W-1:0]  len_limit;
	logic [TYPE_W-1:0] frame_kind;
	logic [7:0]        sum_lo;
	logic [7:0]        sum_hi;
	logic              sum_lo_ok;
	int                n_results;

	ubx_result_t awaited_results[$];

	// fletcher-8 running sum
	task automatic fold(input logic [7:0] b);
		sum_lo = sum_lo + b;
		sum_hi = sum_hi + sum_lo;
	endtask

	// advance the frame state by one received item and work out its result
	task automatic parse_byte(input logic [7:0] b, output ubx_result_t r);
		int unsigned idx;
		idx = frame_pos;
		r = '0;
		r.ev = EV_NONE;
		if (idx == 0) begin
			if (hunt_prev == SYNC_FIRST && b == SYNC_SECOND) begin
				frame_pos = POS_CLASS;
				sum_lo = '0;
				sum_hi = '0;
				sum_lo_ok = 1'b0;
			end
			hunt_prev = b;
		end else begin
			frame_pos = frame_pos + 1'b1;
			if (idx == POS_CLASS) begin
				frame_kind = {b, 8'h00};
				fold(b);
			end else if (idx == POS_ID) begin
				frame_kind[7:0] = b;
				fold(b);
			end else if (idx == POS_LEN_LO) begin
				frame_total = LEN_W'(b);
				fold(b);
			end else if (idx == POS_LEN_HI) begin
				frame_total = {b, frame_total[7:0]} + FRAME_OVERHEAD;
				fold(b);
				// oversized frame is dropped straight after its length
				if (frame_total > len_limit) begin
					frame_pos = '0;
					r.ev = EV_TOO_LONG;
				end
			end else if (idx + 2 < frame_total) begin
				fold(b);
				r.ev = EV_PAYLOAD;
				r.pbyte = b;
				r.poff = OFF_W'(idx - POS_PAYLOAD);
			end else if (idx + 2 == frame_total) begin
				sum_lo_ok = (b == sum_lo);
			end else begin
				// second checksum item closes the frame
				frame_pos = '0;
				if (sum_lo_ok && b == sum_hi)
					r.ev = (frame_kind == TYPE_NAV_PVT) ? EV_GOOD_PVT : EV_GOOD_OTHER;
				else
					r.ev = EV_BAD_SUM;
			end
		end
		r.mtype = frame_kind;
	endtask

	// one line for each of the first REPORT_LINES mismatches, counting all of them
	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (fail_count < REPORT_LINES)
			$display("mismatch on %s at result item %0d: got 0x%0h, expected 0x%0h",
				field, n_results, got, want);
		fail_count++;
	endtask

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin : watch_channels
		ubx_result_t want;
		ubx_result_t got;
		if (!arst_n) begin
			hunt_prev = '0;
			frame_pos = '0;
			frame_total = '0;
			frame_kind = '0;
			sum_lo = '0;
			sum_hi = '0;
			sum_lo_ok = 1'b0;
			len_limit = MAX_LEN_RESET;
			awaited_results.delete();
			fail_count = 0;
			pending = 0;
			n_results = 0;
			n_pvt = 0;
			n_other = 0;
			n_bad_sum = 0;
			n_too_long = 0;
			n_payload = 0;
		end else begin
			// result side first: it belongs to an item accepted earlier
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected item", event_res, 0);
				end else begin
					want = awaited_results.pop_front();
					if (event_res !== want.ev)
						report_mismatch("event_res", event_res, want.ev);
					if (payload_byte !== want.pbyte)
						report_mismatch("payload_byte", payload_byte, want.pbyte);
					if (payload_offset !== want.poff)
						report_mismatch("payload_offset", payload_offset, want.poff);
					if (msg_type !== want.mtype)
						report_mismatch("msg_type", msg_type, want.mtype);
					case (want.ev)
						EV_PAYLOAD: n_payload++;
						EV_GOOD_PVT: n_pvt++;
						EV_GOOD_OTHER: n_other++;
						EV_BAD_SUM: n_bad_sum++;
						EV_TOO_LONG: n_too_long++;
						default: ;
					endcase
				end
				n_results++;
			end
			if (cfg_valid && cfg_ready)
				len_limit = cfg_data;
			if (in_valid && !in_stall) begin
				parse_byte(rx_byte, got);
				awaited_results.push_back(got);
			end
			pending = awaited_results.size();
		end
	end

endmodule

/* dv/ubx_frame_receiver_tb.sv */
// testbench top for the ubx frame receiver: frame stimulus, idle patterns and verdict
module ubx_frame_receiver_tb;
	import ubx_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int PHASE_ITEMS = 75;
	localparam int N_PHASES = 8;
	localparam logic [LEN_W-1:0] LEN_TOP = 17'd65543;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        rx_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [2:0]        event_res;
	logic [7:0]        payload_byte;
	logic [OFF_W-1:0]  payload_offset;
	logic [TYPE_W-1:0] msg_type;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [LEN_W-1:0]  cfg_data = '0;

	int fail_count;
	int pending;
	int n_pvt;
	int n_other;
	int n_bad_sum;
	int n_too_long;
	int n_payload;

	int               snd_idle_pct = 0;
	int               rcv_stall_pct = 0;
	int               cycle_count;
	int               items_sent = 0;
	logic [LEN_W-1:0] cur_max = MAX_LEN_RESET;
	logic [7:0]       tx_bytes[$];

	ubx_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.payload_byte(payload_byte),
		.payload_offset(payload_offset),
		.msg_type(msg_type),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	ubx_frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.payload_byte(payload_byte),
		.payload_offset(payload_offset),
		.msg_type(msg_type),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.n_pvt(n_pvt),
		.n_other(n_other),
		.n_bad_sum(n_bad_sum),
		.n_too_long(n_too_long),
		.n_payload(n_payload)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog on the cycle count
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("ubx_frame_receiver verification failed");
		$finish;
	end

	// receiver stalls
	always @(posedge clk) begin
		out_stall <= (rcv_stall_pct != 0) && ($urandom_range(99) < rcv_stall_pct);
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				snd_idle_pct = 0;
				rcv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				snd_idle_pct = 75;
				rcv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				snd_idle_pct = 0;
				rcv_stall_pct = 75;
			end
			default: begin
				snd_idle_pct = 19;
				rcv_stall_pct = 19;
			end
		endcase
	endtask

	// offer one item, with an optional gap first, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			@(posedge clk);
			while ($urandom_range(99) < snd_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_queued();
		items_sent += tx_bytes.size();
		while (tx_bytes.size() != 0)
			send_byte(tx_bytes.pop_front());
	endtask

	// wait until every expected result item has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [LEN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_max = value;
	endtask

	task automatic queue_header(input logic [7:0] cls, input logic [7:0] id,
			input logic [15:0] len);
		tx_bytes.push_back(SYNC_FIRST);
		tx_bytes.push_back(SYNC_SECOND);
		tx_bytes.push_back(cls);
		tx_bytes.push_back(id);
		tx_bytes.push_back(len[7:0]);
		tx_bytes.push_back(len[15:8]);
	endtask

	// whole frame with random payload; bad selects which checksum item is spoilt
	task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
			input int unsigned len, input logic [1:0] bad);
		logic [7:0] ck_a;
		logic [7:0] ck_b;
		logic [7:0] p;
		logic [7:0] hdr[4];
		hdr = '{cls, id, len[7:0], len[15:8]};
		queue_header(cls, id, len[15:0]);
		ck_a = '0;
		ck_b = '0;
		foreach (hdr[i]) begin
			ck_a += hdr[i];
			ck_b += ck_a;
		end
		repeat (len) begin
			p = 8'($urandom);
			tx_bytes.push_back(p);
			ck_a += p;
			ck_b += ck_a;
		end
		if (bad[0])
			ck_a ^= 8'($urandom_range(255, 1));
		if (bad[1])
			ck_b ^= 8'($urandom_range(255, 1));
		tx_bytes.push_back(ck_a);
		tx_bytes.push_back(ck_b);
	endtask

	task automatic pick_type(output logic [7:0] cls, output logic [7:0] id);
		if ($urandom_range(9) < 3) begin
			{cls, id} = TYPE_NAV_PVT;
		end else begin
			cls = 8'($urandom);
			id = 8'($urandom);
		end
	endtask

	// mostly short payloads, now and then a longer one, kept within the limit unless it is below 8
	function automatic int unsigned pick_len();
		int unsigned len;
		if ($urandom_range(19) == 0)
			len = $urandom_range(80, 25);
		else
			len = $urandom_range(24, 0);
		if (cur_max >= 8 && len + 8 > cur_max)
			len = cur_max - 8;
		return len;
	endfunction

	// mixed traffic: good frames, spoilt checksums, oversize, cut-off frames, line noise
	task automatic random_traffic(input int target);
		int          done_items;
		int          roll;
		int          cut;
		int unsigned len;
		logic [7:0]  cls;
		logic [7:0]  id;
		done_items = 0;
		while (done_items < target) begin
			roll = $urandom_range(99);
			pick_type(cls, id);
			len = pick_len();
			if (roll < 55) begin
				queue_frame(cls, id, len, 2'b00);
			end else if (roll < 67) begin
				queue_frame(cls, id, len, 2'($urandom_range(3, 1)));
			end else if (roll < 77) begin
				if (cur_max < LEN_TOP)
					queue_header(cls, id,
						16'($urandom_range(65535, (cur_max < 8) ? 0 : cur_max - 7)));
				else
					queue_frame(cls, id, len, 2'b00);
			end else if (roll < 87) begin
				queue_frame(cls, id, len, 2'b00);
				cut = $urandom_range(tx_bytes.size() - 1, 1);
				repeat (cut) void'(tx_bytes.pop_back());
			end else begin
				repeat ($urandom_range(8, 1)) begin
					case ($urandom_range(3))
						0: tx_bytes.push_back(SYNC_FIRST);
						1: tx_bytes.push_back(SYNC_SECOND);
						default: tx_bytes.push_back(8'($urandom));
					endcase
				end
			end
			if (roll < 87)
				done_items += tx_bytes.size();
			send_queued();
		end
	endtask

	// main sequence
	initial begin
		logic [LEN_W-1:0] limits[N_PHASES];
		logic [7:0]       cls;
		logic [7:0]       id;
		limits = '{MAX_LEN_RESET, 17'd8, 17'd40, 17'd100, 17'd0, 17'h1FFFF,
			LEN_W'($urandom_range(80, 9)), LEN_TOP};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening: noise, doubled first sync item, empty nav-pvt frame,
		// lone second sync item after a frame, spoilt second checksum, longest length
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(SYNC_FIRST);
		queue_frame(8'h01, 8'h07, 0, 2'b00);
		tx_bytes.push_back(SYNC_SECOND);
		queue_frame(8'hFF, 8'hFF, 2, 2'b10);
		queue_header(8'h00, 8'h00, 16'hFFFF);
		send_queued();

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			if (p != 0)
				cfg_write(limits[p]);
			set_idle(idle_mode_t'(p % 4));
			// frame exactly at the limit, then a header one item over it; below 8 only an empty header
			pick_type(cls, id);
			if (cur_max < 8) begin
				queue_header(cls, id, 16'h0000);
			end else if (cur_max <= 100) begin
				queue_frame(cls, id, cur_max - 8, 2'b00);
				queue_header(cls, id, 16'(cur_max - 7));
			end else if (cur_max < LEN_TOP) begin
				// large limit: only the header one item over it
				queue_header(cls, id, 16'(cur_max - 7));
			end else if (cur_max == LEN_TOP) begin
				// longest length is taken; the frame stays open for the rest of the run
				queue_header(cls, id, 16'hFFFF);
			end
			send_queued();
			random_traffic(PHASE_ITEMS);
		end

		settle();
		repeat (6) @(posedge clk);
		$display("ran %0d input items over %0d length limits and four idle patterns",
			items_sent, N_PHASES);
		$display("seen %0d nav-pvt, %0d other, %0d bad checksum, %0d dropped, %0d payload",
			n_pvt, n_other, n_bad_sum, n_too_long, n_payload);
		if (fail_count == 0)
			$display("ubx_frame_receiver verification clean");
		else
			$display("ubx_frame_receiver verification failed");
		$finish;
	end

endmodule
